// ----- design/tmas_pkg.sv -----
// Shared constants, types and helpers for the trajectory smoother.
// Used by every module in this folder; depends on nothing.
`default_nettype none
package tmas_pkg;

   localparam int MAX_HALF_WINDOW = 63;
   localparam int HIST_DEPTH      = 128;
   localparam int INDEX_W         = 20;

   localparam int DELTA_W   = 32;
   localparam int POS_W     = 48;
   localparam int SUM_W     = 56;
   localparam int HW_W      = 6;
   localparam int DIST_W    = $clog2(HIST_DEPTH);
   localparam int DIVD_W    = SUM_W + 1;
   localparam int DCNT_W    = $clog2(DIVD_W + 1);
   localparam int WIDE_W    = DIVD_W + 1;
   localparam int CSR_ADDR_W = 3;

   localparam int WIN_LIM_I = (MAX_HALF_WINDOW < (HIST_DEPTH - 1) / 2) ?
                              MAX_HALF_WINDOW : (HIST_DEPTH - 1) / 2;
   localparam logic [HW_W-1:0] WIN_LIM = HW_W'(WIN_LIM_I);
   localparam logic [HW_W-1:0] HALF_WINDOW_RESET = HW_W'(30);

   localparam logic [CSR_ADDR_W-3:0] REG_HALF_WINDOW = '0;

   localparam logic signed [WIDE_W-1:0] WIDE_POS_MAX =
      {{(WIDE_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] WIDE_POS_MIN =
      {{(WIDE_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] a;
   } pos_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLAN,
      ST_RANGE,
      ST_SCAN,
      ST_DIVS,
      ST_DIV,
      ST_OUT
   } state_type;

   function automatic logic signed [POS_W-1:0] sat_pos(logic signed [WIDE_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > WIDE_POS_MAX) begin
         r = WIDE_POS_MAX[POS_W-1:0];
      end else if (v < WIDE_POS_MIN) begin
         r = WIDE_POS_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(logic signed [POS_W-1:0] v);
      return {{(WIDE_W-POS_W){v[POS_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

// ----- design/tmas_cell.sv -----
// One cell of the history ring: holds the cumulative position of one frame.
// Depends on tmas_pkg.
`default_nettype none
module tmas_cell
   import tmas_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    shift_en,
   input  wire pos_type din,
   output pos_type      dout
);

   pos_type pos_ff;
   pos_type pos_in;

   assign pos_in = shift_en ? din : pos_ff;

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   assign dout = pos_ff;

endmodule
`default_nettype wire

// ----- design/tmas_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on tmas_pkg.
`default_nettype none
module tmas_divider
   import tmas_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIST_W-1:0] divisor,
   output logic                   done,
   output logic [DIVD_W-1:0]      quotient
);

   logic [DIVD_W-1:0] quot_ff, quot_in;
   logic [DIST_W-1:0] rem_ff, rem_in;
   logic [DIST_W-1:0] dvs_ff, dvs_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIST_W:0]   shifted;
   logic [DIST_W:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[DIVD_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIST_W]) begin
            rem_in  = trial[DIST_W-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DIST_W-1:0];
            quot_in = {quot_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
`default_nettype wire

// ----- design/trajectory_moving_average_smoother.sv -----
// Top level of the centered moving-average trajectory smoother.
// Depends on tmas_pkg, tmas_cell and tmas_divider.
`default_nettype none
// Each item is one frame delta; the block accumulates it into the camera
// trajectory and stores that position in a ring of 128 cells. An item with
// no result returns to idle from the planning state. Every correction
// costs one full rotation of the ring (the window sum is taken from the
// ring's tail cell) plus a serial division; an end-of-sequence item
// produces up to 64 results back to back. One item is in work at a
// time; req_tready is high only while the block is idle.
module trajectory_moving_average_smoother
   import tmas_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [31:0] delta_x, [63:32] delta_y, [95:64] delta_angle
   input  wire logic [95:0]           req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [19:0] frame_index, [67:20] corr_x, [115:68] corr_y,
   // [163:116] corr_angle, [167:164] zero
   output logic [167:0]               rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   state_type state_ff, state_in;

   logic [HW_W-1:0]    hw_ff, hw_in;
   pos_type            cum_ff, cum_in;
   logic [INDEX_W-1:0] frames_ff, frames_in;
   logic [INDEX_W-1:0] f_ff, f_in;
   logic [HW_W-1:0]    w_ff, w_in;
   logic               eos_ff, eos_in;
   logic [DIST_W-1:0]  di_ff, di_in;
   logic [DIST_W-1:0]  dmin_ff, dmin_in;
   logic [DIST_W-1:0]  dmax_ff, dmax_in;
   logic [DIST_W-1:0]  n_ff, n_in;
   logic [DIST_W-1:0]  t_ff, t_in;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sy_ff, sy_in, sa_ff, sa_in;
   pos_type            cur_ff, cur_in;
   logic               rv_ff, rv_in;
   logic               rlast_ff, rlast_in;
   logic [INDEX_W-1:0] ridx_ff, ridx_in;
   pos_type            rcorr_ff, rcorr_in;

   pos_type            new_cum;
   pos_type            ring_q [HIST_DEPTH];
   pos_type            ring_head;
   pos_type            tail;
   logic               shift_en;
   logic               accept;
   logic               csr_wr;
   logic [INDEX_W-1:0] w_ext;
   logic [DIST_W-1:0]  w_dist;
   logic [INDEX_W-1:0] i_idx;
   logic [DIST_W-1:0]  d_cur;
   logic               div_start;
   logic               done_x, done_y, done_a;
   logic [DIVD_W-1:0]  q_x, q_y, q_a;

   function automatic logic [DIVD_W-1:0] dividend_of(logic signed [SUM_W-1:0] s,
                                                     logic [DIST_W-1:0] n);
      logic [DIVD_W-1:0] ext;
      logic [DIVD_W-1:0] mag;
      ext = {s[SUM_W-1], s};
      mag = s[SUM_W-1] ? (~ext + 1'b1) : ext;
      return mag + DIVD_W'(n >> 1);
   endfunction

   function automatic logic signed [POS_W-1:0] corr_of(logic [DIVD_W-1:0] q, logic neg,
                                                       logic signed [POS_W-1:0] cur);
      logic signed [WIDE_W-1:0] qs;
      logic signed [WIDE_W-1:0] avg;
      qs  = {1'b0, q};
      avg = neg ? -qs : qs;
      return sat_pos(avg - widen(cur));
   endfunction

   function automatic logic signed [SUM_W-1:0] sext_sum(logic signed [POS_W-1:0] v);
      return {{(SUM_W-POS_W){v[POS_W-1]}}, v};
   endfunction

   function automatic logic signed [WIDE_W-1:0] sext_delta(logic [DELTA_W-1:0] v);
      return {{(WIDE_W-DELTA_W){v[DELTA_W-1]}}, v};
   endfunction

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign hw_in  = (csr_wr && csr_paddr[CSR_ADDR_W-1:2] == REG_HALF_WINDOW) ?
                   csr_pwdata[HW_W-1:0] : hw_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_HALF_WINDOW) ?
                       {{(32-HW_W){1'b0}}, hw_ff} : '0;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   assign new_cum.x = sat_pos(widen(cum_ff.x) + sext_delta(req_tdata[31:0]));
   assign new_cum.y = sat_pos(widen(cum_ff.y) + sext_delta(req_tdata[63:32]));
   assign new_cum.a = sat_pos(widen(cum_ff.a) + sext_delta(req_tdata[95:64]));

   // History ring: shifts a new position in on accept, rotates while scanning
   assign tail      = ring_q[HIST_DEPTH-1];
   assign ring_head = (state_ff == ST_IDLE) ? new_cum : tail;
   assign shift_en  = accept | (state_ff == ST_SCAN);

   for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_cell
      if (j == 0) begin : g_head
         tmas_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .din      (ring_head),
            .dout     (ring_q[j])
         );
      end else begin : g_body
         tmas_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .din      (ring_q[j-1]),
            .dout     (ring_q[j])
         );
      end
   end

   tmas_divider u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (dividend_of(sx_ff, n_ff)), .divisor (n_ff),
      .done (done_x), .quotient (q_x)
   );
   tmas_divider u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (dividend_of(sy_ff, n_ff)), .divisor (n_ff),
      .done (done_y), .quotient (q_y)
   );
   tmas_divider u_div_a (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (dividend_of(sa_ff, n_ff)), .divisor (n_ff),
      .done (done_a), .quotient (q_a)
   );

   assign w_ext  = {{(INDEX_W-HW_W){1'b0}}, w_ff};
   assign w_dist = {{(DIST_W-HW_W){1'b0}}, w_ff};
   assign i_idx  = f_ff - {{(INDEX_W-DIST_W){1'b0}}, di_ff};
   // ring cell at the tail holds the frame this many steps behind the newest
   assign d_cur  = DIST_W'(HIST_DEPTH - 1) - t_ff;

   always_comb begin
      state_in  = state_ff;
      cum_in    = cum_ff;
      frames_in = frames_ff;
      f_in      = f_ff;
      w_in      = w_ff;
      eos_in    = eos_ff;
      di_in     = di_ff;
      dmin_in   = dmin_ff;
      dmax_in   = dmax_ff;
      n_in      = n_ff;
      t_in      = t_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      sa_in     = sa_ff;
      cur_in    = cur_ff;
      rv_in     = rv_ff;
      rlast_in  = rlast_ff;
      ridx_in   = ridx_ff;
      rcorr_in  = rcorr_ff;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               f_in   = frames_ff;
               w_in   = (hw_ff > WIN_LIM) ? WIN_LIM : hw_ff;
               eos_in = req_tlast;
               if (req_tlast) begin
                  cum_in    = '0;
                  frames_in = '0;
               end else begin
                  cum_in    = new_cum;
                  frames_in = frames_ff + 1'b1;
               end
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            if (eos_ff) begin
               di_in    = (f_ff < w_ext) ? f_ff[DIST_W-1:0] : w_dist;
               state_in = ST_RANGE;
            end else if (f_ff >= w_ext) begin
               di_in    = w_dist;
               state_in = ST_RANGE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RANGE: begin
            dmax_in  = (i_idx >= w_ext) ? di_ff + w_dist : f_ff[DIST_W-1:0];
            dmin_in  = (di_ff >= w_dist) ? di_ff - w_dist : '0;
            n_in     = dmax_in - dmin_in + 1'b1;
            sx_in    = '0;
            sy_in    = '0;
            sa_in    = '0;
            t_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (d_cur >= dmin_ff && d_cur <= dmax_ff) begin
               sx_in = sx_ff + sext_sum(tail.x);
               sy_in = sy_ff + sext_sum(tail.y);
               sa_in = sa_ff + sext_sum(tail.a);
            end
            if (d_cur == di_ff) begin
               cur_in = tail;
            end
            t_in = t_ff + 1'b1;
            if (t_ff == DIST_W'(HIST_DEPTH - 1)) begin
               state_in = ST_DIVS;
            end
         end
         ST_DIVS: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (done_x & done_y & done_a) begin
               rcorr_in.x = corr_of(q_x, sx_ff[SUM_W-1], cur_ff.x);
               rcorr_in.y = corr_of(q_y, sy_ff[SUM_W-1], cur_ff.y);
               rcorr_in.a = corr_of(q_a, sa_ff[SUM_W-1], cur_ff.a);
               ridx_in    = i_idx;
               rlast_in   = eos_ff && (di_ff == '0);
               rv_in      = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rv_in = 1'b0;
               if (eos_ff && di_ff != '0) begin
                  di_in    = di_ff - 1'b1;
                  state_in = ST_RANGE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      f_ff     <= f_in;
      w_ff     <= w_in;
      eos_ff   <= eos_in;
      di_ff    <= di_in;
      dmin_ff  <= dmin_in;
      dmax_ff  <= dmax_in;
      n_ff     <= n_in;
      t_ff     <= t_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sa_ff    <= sa_in;
      cur_ff   <= cur_in;
      rlast_ff <= rlast_in;
      ridx_ff  <= ridx_in;
      rcorr_ff <= rcorr_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         hw_ff     <= HALF_WINDOW_RESET;
         cum_ff    <= '0;
         frames_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hw_ff     <= hw_in;
         cum_ff    <= cum_in;
         frames_ff <= frames_in;
         rv_ff     <= rv_in;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {4'b0000, rcorr_ff.a, rcorr_ff.y, rcorr_ff.x, ridx_ff};

endmodule
`default_nettype wire
